[hdl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger implies a consequence at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Checks that a trigger implies a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rgm5_pkg.sv]
// Constants for the range-gated median-of-five distance filter.
`timescale 1ns / 1ps

package rgm5_pkg;

    localparam int WINDOW              = 5;
    localparam int SLOT_BITS           = 3;
    localparam int RANK_BITS           = 3;
    localparam int MEDIAN_RANK         = WINDOW / 2;
    localparam int RAW_BITS            = 16;
    localparam int OUT_BITS            = 17;
    localparam int IN_TDATA_BITS       = 16;
    localparam int OUT_TDATA_BITS      = 24;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    localparam logic [RAW_BITS-1:0] MAX_RANGE_RESET = 16'd400;
    localparam logic [OUT_BITS-1:0] OUT_OF_RANGE    = '1;

endpackage

[hdl/range_gated_median5_filter.sv]
// Range-gated median-of-five distance filter, top level.
//
//  Channel   Direction  Handshake              Payload
//  s_axis    in         tvalid / tready        tdata[15:0]  raw_distance_cm
//  m_axis    out        tvalid / tready        tdata[16:0]  filtered_distance_cm
//  cfg       in         cfg_we (no wait)       cfg_wdata    max_range_cm
//
// Each beat passes through the ring update and the rank-count median network, which sit
// combinationally between the input handshake and the output register.
// A beat is accepted in every cycle in which the output register is empty or drained.
// Reset clears the write slot, the ring-full flag and the output valid; the ring is not cleared.
// A stall on m_axis holds the output register and stops input acceptance.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module range_gated_median5_filter #(
    parameter int SAMPLE_BITS = rgm5_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rgm5_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [15:0] raw_distance_cm
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rgm5_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,  // [16:0] filtered_distance_cm
    input  logic                                cfg_we,
    input  logic [rgm5_pkg::RAW_BITS-1:0]       cfg_wdata
);

    logic [rgm5_pkg::RAW_BITS-1:0]  max_range_reg;
    logic [SAMPLE_BITS-1:0]         ring_reg [rgm5_pkg::WINDOW];
    logic [SAMPLE_BITS-1:0]         ring_next [rgm5_pkg::WINDOW];
    logic [rgm5_pkg::SLOT_BITS-1:0] write_slot_reg;
    logic [rgm5_pkg::SLOT_BITS-1:0] write_slot_next;
    logic                           ring_full_reg;
    logic                           ring_full_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [rgm5_pkg::OUT_BITS-1:0]  out_data_reg;
    logic [rgm5_pkg::OUT_BITS-1:0]  out_data_next;

    logic                                 accept;
    logic                                 in_range;
    logic [SAMPLE_BITS+rgm5_pkg::RAW_BITS-1:0] raw_wide;
    logic [SAMPLE_BITS-1:0]               raw_sample;
    logic [SAMPLE_BITS-1:0]               median;
    logic [SAMPLE_BITS+rgm5_pkg::OUT_BITS-1:0] median_wide;
    logic [rgm5_pkg::RANK_BITS-1:0]       rank [rgm5_pkg::WINDOW];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_range      = s_axis_tdata <= max_range_reg;
    assign raw_wide      = {{SAMPLE_BITS{1'b0}}, s_axis_tdata};
    assign raw_sample    = raw_wide[SAMPLE_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < rgm5_pkg::WINDOW; i++)
        begin
            ring_next[i] = ring_reg[i];
        end
        write_slot_next = write_slot_reg;
        ring_full_next  = ring_full_reg;
        if (in_range)
        begin
            ring_next[write_slot_reg] = raw_sample;
            if (write_slot_reg == rgm5_pkg::SLOT_BITS'(rgm5_pkg::WINDOW - 1))
            begin
                write_slot_next = '0;
                ring_full_next  = 1'b1;
            end
            else
            begin
                write_slot_next = write_slot_reg + 1'b1;
            end
        end
    end

    // Each sample's rank is the count of samples smaller than it; an equal sample counts when it is in a lower slot.
    always_comb
    begin
        median = '0;
        for (int i = 0; i < rgm5_pkg::WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < rgm5_pkg::WINDOW; j++)
            begin
                if (j != i)
                begin
                    if ((ring_next[j] < ring_next[i]) ||
                        ((ring_next[j] == ring_next[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
            if (rank[i] == rgm5_pkg::RANK_BITS'(rgm5_pkg::MEDIAN_RANK))
            begin
                median = median | ring_next[i];
            end
        end
    end

    assign median_wide = {{rgm5_pkg::OUT_BITS{1'b0}}, median};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (ring_full_next)
            begin
                out_data_next = median_wide[rgm5_pkg::OUT_BITS-1:0];
            end
            else if (in_range)
            begin
                out_data_next = {1'b0, s_axis_tdata};
            end
            else
            begin
                out_data_next = rgm5_pkg::OUT_OF_RANGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg  <= rgm5_pkg::MAX_RANGE_RESET;
            write_slot_reg <= '0;
            ring_full_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_range_reg <= cfg_wdata;
            end
            if (accept)
            begin
                write_slot_reg <= write_slot_next;
                ring_full_reg  <= ring_full_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < rgm5_pkg::WINDOW; i++)
            begin
                ring_reg[i] <= ring_next[i];
            end
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(rgm5_pkg::OUT_TDATA_BITS - rgm5_pkg::OUT_BITS){1'b0}}, out_data_reg};

    `ASSERT_ALWAYS(a_slot_in_window, clk, rst_n,
        write_slot_reg < rgm5_pkg::SLOT_BITS'(rgm5_pkg::WINDOW), "write slot left the window")
    `ASSERT_IMPLIES(a_full_on_wrap, clk, rst_n,
        $rose(ring_full_reg), write_slot_reg == '0, "ring became full without wrapping")
    `ASSERT_NEXT(a_full_sticky, clk, rst_n,
        ring_full_reg, ring_full_reg, "ring full flag cleared after being set")
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n,
        accept, !(out_valid_reg && !m_axis_tready), "beat accepted over a held result")

endmodule
